// ----- hdl/argtok_pkg.sv -----
// ----------------------------------------------------------------------------
// argtok_pkg
// Shared types, character constants and the escape table for the
// command-line argument tokenizer.
// ----------------------------------------------------------------------------
package argtok_pkg;

   // longest string whose byte positions are counted before saturating
   localparam int unsigned MAX_LEN = 4096;
   localparam int unsigned POS_LIMIT_INT = (MAX_LEN - 1 > 4095) ? 4095 : MAX_LEN - 1;
   localparam logic [11:0] POS_LIMIT = 12'(POS_LIMIT_INT);
   localparam logic [11:0] ARGS_LIMIT = 12'hFFF;

   // characters the parser reacts to
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_QUOTE     = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHR_VTAB      = 8'h0B;
   localparam logic [7:0] CHR_BELL      = 8'h07;
   localparam logic [7:0] CHR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHR_FORMFEED  = 8'h0C;
   localparam logic [7:0] CHR_RETURN    = 8'h0D;

   // parser modes
   typedef enum logic [4:0] {
      MODE_BLANK     = 5'b00001,
      MODE_TEXT      = 5'b00010,
      MODE_QUOTE     = 5'b00100,
      MODE_ESC_QUOTE = 5'b01000,
      MODE_ESC_TEXT  = 5'b10000
   } mode_type;

   // error codes
   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_ESCAPE       = 2'd1,
      ERR_UNTERMINATED = 2'd2
   } error_type;

   // parser state carried from byte to byte
   typedef struct packed {
      mode_type    mode;
      logic [11:0] args;
      logic [11:0] pos;
      logic        discard;
   } state_type;

   // one result per byte
   typedef struct packed {
      logic        char_valid;
      logic [7:0]  char_out;
      logic        arg_end;
      logic [11:0] arg_count;
      error_type   error_code;
      logic [11:0] error_position;
      logic        string_done;
   } result_type;

   localparam state_type STATE_RESET = '{
      mode:    MODE_BLANK,
      args:    12'd0,
      pos:     12'd0,
      discard: 1'b0
   };

   // escape translation: bit 8 set when the escape is known
   function automatic logic [8:0] escape_byte(input logic [7:0] c, input logic allow_space);
      logic [8:0] r;
      r = 9'd0;
      case (c)
         8'h6E: r = {1'b1, CHR_NEWLINE};
         8'h74: r = {1'b1, CHR_TAB};
         8'h76: r = {1'b1, CHR_VTAB};
         8'h61: r = {1'b1, CHR_BELL};
         8'h62: r = {1'b1, CHR_BACKSPACE};
         8'h66: r = {1'b1, CHR_FORMFEED};
         8'h72: r = {1'b1, CHR_RETURN};
         CHR_BACKSLASH: r = {1'b1, CHR_BACKSLASH};
         CHR_QUOTE: r = {1'b1, CHR_QUOTE};
         CHR_SPACE: r = allow_space ? {1'b1, CHR_SPACE} : 9'd0;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/argtok_step.sv -----
// ----------------------------------------------------------------------------
// argtok_step
// Next-state and result logic of the tokenizer for one input byte.
// ----------------------------------------------------------------------------
module argtok_step
   import argtok_pkg::*;
(
   input  state_type  cur_state,
   input  logic [7:0] char_in,
   input  logic       is_last,
   output state_type  nxt_state,
   output result_type result
);

   logic       blank;
   logic [8:0] esc;
   mode_type   mode;
   logic       valid;
   logic [7:0] ch;
   logic       arg_end;
   error_type  err;
   logic [11:0] args;
   logic       discard;

   assign blank = (char_in == CHR_SPACE) || (char_in == CHR_TAB);
   assign esc   = escape_byte(char_in, cur_state.mode == MODE_ESC_TEXT);

   // mode machine
   always_comb begin
      mode    = cur_state.mode;
      valid   = 1'b0;
      ch      = 8'd0;
      arg_end = 1'b0;
      err     = ERR_NONE;
      args    = cur_state.args;
      discard = cur_state.discard;
      if (!cur_state.discard) begin
         unique case (cur_state.mode)
            MODE_TEXT: begin
               if (blank) begin
                  arg_end = 1'b1;
                  mode    = MODE_BLANK;
               end else if (char_in == CHR_BACKSLASH) begin
                  mode = MODE_ESC_TEXT;
               end else begin
                  valid   = 1'b1;
                  ch      = char_in;
                  arg_end = is_last;
               end
            end
            MODE_QUOTE: begin
               if (char_in == CHR_QUOTE) begin
                  arg_end = 1'b1;
                  mode    = MODE_BLANK;
               end else if (char_in == CHR_BACKSLASH) begin
                  mode = MODE_ESC_QUOTE;
               end else begin
                  valid = 1'b1;
                  ch    = char_in;
               end
            end
            MODE_ESC_QUOTE: begin
               if (esc[8]) begin
                  valid = 1'b1;
                  ch    = esc[7:0];
                  mode  = MODE_QUOTE;
               end else begin
                  err = ERR_ESCAPE;
               end
            end
            MODE_ESC_TEXT: begin
               if (esc[8]) begin
                  valid   = 1'b1;
                  ch      = esc[7:0];
                  mode    = MODE_TEXT;
                  arg_end = is_last;
               end else begin
                  err = ERR_ESCAPE;
               end
            end
            default: begin
               if (blank) begin
                  mode = MODE_BLANK;
               end else if (char_in == CHR_QUOTE) begin
                  mode = MODE_QUOTE;
               end else if (char_in == CHR_BACKSLASH) begin
                  mode = MODE_ESC_TEXT;
               end else begin
                  valid   = 1'b1;
                  ch      = char_in;
                  mode    = is_last ? MODE_BLANK : MODE_TEXT;
                  arg_end = is_last;
               end
            end
         endcase
         // saturating argument count
         if (arg_end && (cur_state.args < ARGS_LIMIT)) begin
            args = cur_state.args + 12'd1;
         end
         // string ended inside quotes or an escape
         if ((err == ERR_NONE) && is_last &&
             ((mode == MODE_QUOTE) || (mode == MODE_ESC_QUOTE) || (mode == MODE_ESC_TEXT))) begin
            err = ERR_UNTERMINATED;
         end
         if (err == ERR_ESCAPE) begin
            discard = 1'b1;
         end
      end
   end

   // result fields
   always_comb begin
      result.char_valid     = valid;
      result.char_out       = ch;
      result.arg_end        = arg_end;
      result.arg_count      = args;
      result.error_code     = err;
      result.error_position = (err != ERR_NONE) ? cur_state.pos : 12'd0;
      result.string_done    = is_last;
   end

   // state for the next byte, cleared after the last byte of a string
   always_comb begin
      if (is_last) begin
         nxt_state = STATE_RESET;
      end else begin
         nxt_state.mode    = mode;
         nxt_state.args    = args;
         nxt_state.discard = discard;
         nxt_state.pos     = (cur_state.pos < POS_LIMIT) ? cur_state.pos + 12'd1
                                                         : cur_state.pos;
      end
   end

endmodule

// ----- hdl/argument_tokenizer.sv -----
// ----------------------------------------------------------------------------
// argument_tokenizer
// Splits a command string, one byte per request, into arguments with quote
// grouping and backslash escapes; one result per request.
// ----------------------------------------------------------------------------
// the result of a request is registered and appears in the cycle after it is accepted
// throughput: one byte per cycle while the result channel is not stalled, set by the single registered parser step
// a new request is taken when the output register is empty or drained that cycle
// reset: synchronous, clears parser mode, counts, discard flag and output valid
// ----------------------------------------------------------------------------
module argument_tokenizer
   import argtok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // is_last
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] char_out, [8] arg_end, [20:9] arg_count,
                                    // [22:21] error_code, [34:23] error_position, zero pad
   output logic        rsp_tuser,   // char_valid
   output logic        rsp_tlast    // string_done
);

   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       req_fire;

   // take a request whenever the output register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // parser step
   argtok_step u_step (
      .cur_state (state_ff),
      .char_in   (req_tdata),
      .is_last   (req_tlast),
      .nxt_state (state_in),
      .result    (result_in)
   );

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   // result packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.char_valid;
   assign rsp_tlast  = result_ff.string_done;
   assign rsp_tdata  = {5'd0, result_ff.error_position, result_ff.error_code,
                        result_ff.arg_count, result_ff.arg_end, result_ff.char_out};

   // state returns to reset after the last byte of a string
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=>
         (state_ff.mode == MODE_BLANK && state_ff.pos == 12'd0 &&
          state_ff.args == 12'd0 && !state_ff.discard))
      else $error("state not cleared after last byte");

   // discarding only follows a bad escape
   a_discard_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff.discard |-> (state_ff.mode == MODE_ESC_QUOTE || state_ff.mode == MODE_ESC_TEXT))
      else $error("discarding outside an escape");

   // an unknown escape result never carries an argument byte or an argument end
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.error_code == ERR_ESCAPE) |->
         (!result_ff.char_valid && !result_ff.arg_end))
      else $error("error result carries data");

   // while discarding a byte gives an empty result
   a_discard_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_fire && state_ff.discard) |=>
         (!result_ff.char_valid && !result_ff.arg_end && result_ff.error_code == ERR_NONE))
      else $error("output while discarding");

endmodule

// ----- tb/argument_tokenizer_test.sv -----
// ----------------------------------------------------------------------------
// argument_tokenizer_test
// Self-checking bench for the command-line argument tokenizer. A directed
// table (single-byte strings, escapes, quotes, errors, discarding) is
// followed by random strings, mostly well-formed token sequences, with a
// few broken ones and raw noise. Every result is compared field by field
// against a typed row or a bench-side parser; both channels idle randomly.
// ----------------------------------------------------------------------------
module argument_tokenizer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import argtok_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 900;
   localparam int QUIET_TAIL = 150;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       typed;
      result_type want;
   } request_item;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   request_item byte_stream[$];
   result_type  expected_results[$];
   request_item driven_byte;
   int          failures = 0;
   int          accepted_bytes = 0;
   int          returned_results = 0;
   int          cycle_count = 0;
   int          send_gap = 0;
   int          recv_stall = 0;

   // bench copy of the parser state
   mode_type    tok_mode;
   logic [11:0] tok_args;
   logic [11:0] tok_pos;
   logic        tok_discard;

   argument_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // escape letters; space only counts outside quotes
   function automatic logic decode_escape(input logic [7:0] c, input logic allow_space,
                                          output logic [7:0] b);
      logic known;
      known = 1'b1;
      b = 8'd0;
      case (c)
         "n": b = CHR_NEWLINE;
         "t": b = CHR_TAB;
         "v": b = CHR_VTAB;
         "a": b = CHR_BELL;
         "b": b = CHR_BACKSPACE;
         "f": b = CHR_FORMFEED;
         "r": b = CHR_RETURN;
         CHR_BACKSLASH: b = CHR_BACKSLASH;
         CHR_QUOTE: b = CHR_QUOTE;
         CHR_SPACE: begin
            if (allow_space) b = CHR_SPACE;
            else known = 1'b0;
         end
         default: known = 1'b0;
      endcase
      return known;
   endfunction

   function automatic void clear_tokenizer();
      tok_mode = MODE_BLANK;
      tok_args = 12'd0;
      tok_pos = 12'd0;
      tok_discard = 1'b0;
   endfunction

   // one parser step: result for one byte, state updated
   function automatic result_type tokenize_byte(input logic [7:0] c, input logic last);
      result_type r;
      mode_type   m;
      logic       blank;
      logic [7:0] tr;
      r = '0;
      r.error_code = ERR_NONE;
      m = tok_mode;
      blank = (c == CHR_SPACE) || (c == CHR_TAB);
      if (!tok_discard) begin
         case (m)
            MODE_TEXT: begin
               if (blank) begin
                  r.arg_end = 1'b1;
                  m = MODE_BLANK;
               end else if (c == CHR_BACKSLASH) begin
                  m = MODE_ESC_TEXT;
               end else begin
                  r.char_valid = 1'b1;
                  r.char_out = c;
                  r.arg_end = last;
               end
            end
            MODE_QUOTE: begin
               if (c == CHR_QUOTE) begin
                  r.arg_end = 1'b1;
                  m = MODE_BLANK;
               end else if (c == CHR_BACKSLASH) begin
                  m = MODE_ESC_QUOTE;
               end else begin
                  r.char_valid = 1'b1;
                  r.char_out = c;
               end
            end
            MODE_ESC_QUOTE: begin
               if (decode_escape(c, 1'b0, tr)) begin
                  r.char_valid = 1'b1;
                  r.char_out = tr;
                  m = MODE_QUOTE;
               end else begin
                  r.error_code = ERR_ESCAPE;
               end
            end
            MODE_ESC_TEXT: begin
               if (decode_escape(c, 1'b1, tr)) begin
                  r.char_valid = 1'b1;
                  r.char_out = tr;
                  r.arg_end = last;
                  m = MODE_TEXT;
               end else begin
                  r.error_code = ERR_ESCAPE;
               end
            end
            default: begin
               if (blank) begin
                  m = MODE_BLANK;
               end else if (c == CHR_QUOTE) begin
                  m = MODE_QUOTE;
               end else if (c == CHR_BACKSLASH) begin
                  m = MODE_ESC_TEXT;
               end else begin
                  r.char_valid = 1'b1;
                  r.char_out = c;
                  r.arg_end = last;
                  m = last ? MODE_BLANK : MODE_TEXT;
               end
            end
         endcase
         if (r.arg_end && tok_args != ARGS_LIMIT) tok_args = tok_args + 12'd1;
         if (r.error_code == ERR_NONE && last &&
             (m == MODE_QUOTE || m == MODE_ESC_QUOTE || m == MODE_ESC_TEXT))
            r.error_code = ERR_UNTERMINATED;
         if (r.error_code == ERR_ESCAPE) tok_discard = 1'b1;
         tok_mode = m;
      end
      r.arg_count = tok_args;
      r.error_position = (r.error_code != ERR_NONE) ? tok_pos : 12'd0;
      r.string_done = last;
      if (last) clear_tokenizer();
      else if (tok_pos < POS_LIMIT) tok_pos = tok_pos + 12'd1;
      return r;
   endfunction

   function automatic result_type make_result(input logic valid, input logic [7:0] c,
                                              input logic fin, input int cnt,
                                              input error_type err, input int pos,
                                              input logic done);
      result_type r;
      r.char_valid = valid;
      r.char_out = c;
      r.arg_end = fin;
      r.arg_count = 12'(cnt);
      r.error_code = err;
      r.error_position = 12'(pos);
      r.string_done = done;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] c, input logic last, input logic typed,
                          input result_type want);
      request_item it;
      it.data = c;
      it.last = last;
      it.typed = typed;
      it.want = want;
      byte_stream.push_back(it);
   endtask

   // ordinary argument byte: no blank, quote or backslash
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(0, 255));
         else c = 8'($urandom_range(33, 126));
      end while (c == CHR_SPACE || c == CHR_TAB || c == CHR_QUOTE || c == CHR_BACKSLASH);
      return c;
   endfunction

   function automatic logic [7:0] known_escape(input logic allow_space);
      case ($urandom_range(0, allow_space ? 9 : 8))
         0: return "n";
         1: return "t";
         2: return "v";
         3: return "a";
         4: return "b";
         5: return "f";
         6: return "r";
         7: return CHR_BACKSLASH;
         8: return CHR_QUOTE;
         default: return CHR_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] unknown_escape(input logic allow_space);
      logic [7:0] c;
      logic [7:0] dummy;
      do c = 8'($urandom_range(0, 255));
      while (decode_escape(c, allow_space, dummy));
      return c;
   endfunction

   // one random command string; returns its length
   function automatic int add_random_string();
      logic [7:0] s[$];
      int flavor;
      int ntok;
      int k;
      request_item it;
      flavor = $urandom_range(0, 99);
      if (flavor < 8) begin
         // raw noise
         repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(0, 255)));
      end else begin
         ntok = $urandom_range(0, 6);
         for (int t = 0; t < ntok; t++) begin
            k = $urandom_range(0, 9);
            if (k < 4) begin
               repeat ($urandom_range(1, 5)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     s.push_back(CHR_BACKSLASH);
                     s.push_back(known_escape(1'b1));
                  end else begin
                     s.push_back(plain_byte());
                  end
               end
            end else if (k < 7) begin
               s.push_back(CHR_QUOTE);
               repeat ($urandom_range(0, 5)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     s.push_back(CHR_BACKSLASH);
                     s.push_back(known_escape(1'b0));
                  end else if ($urandom_range(0, 5) == 0) begin
                     s.push_back($urandom_range(0, 1) ? CHR_SPACE : CHR_TAB);
                  end else begin
                     s.push_back(plain_byte());
                  end
               end
               s.push_back(CHR_QUOTE);
            end else begin
               repeat ($urandom_range(1, 3))
                  s.push_back($urandom_range(0, 1) ? CHR_SPACE : CHR_TAB);
            end
            // unknown escape in the middle, rest of string discarded
            if (flavor >= 92 && t == ntok / 2) begin
               s.push_back(CHR_BACKSLASH);
               s.push_back(unknown_escape($urandom_range(0, 1)));
            end
         end
         // broken endings: open quote or lone backslash
         if (flavor >= 8 && flavor < 14) begin
            s.push_back(CHR_QUOTE);
            repeat ($urandom_range(0, 3)) s.push_back(plain_byte());
            if ($urandom_range(0, 1)) s.push_back(CHR_BACKSLASH);
         end else if (flavor >= 14 && flavor < 19) begin
            s.push_back(CHR_BACKSLASH);
         end
         if (s.size() == 0) s.push_back(8'($urandom_range(0, 255)));
      end
      foreach (s[i]) begin
         it.data = s[i];
         it.last = (i == s.size() - 1);
         it.typed = 1'b0;
         it.want = '0;
         byte_stream.push_back(it);
      end
      return s.size();
   endfunction

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // request side: predict on acceptance, then load the next request
   always @(posedge clock) begin
      if (reset) begin
         clear_tokenizer();
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            result_type predicted;
            predicted = tokenize_byte(driven_byte.data, driven_byte.last);
            expected_results.push_back(driven_byte.typed ? driven_byte.want : predicted);
            accepted_bytes++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (byte_stream.size() != 0) begin
               driven_byte = byte_stream.pop_front();
               req_tdata <= driven_byte.data;
               req_tlast <= driven_byte.last;
               req_tvalid <= 1'b1;
               if (byte_stream.size() > QUIET_TAIL && (accepted_bytes / 128) % 3 != 0 &&
                   $urandom_range(0, 7) == 0)
                  send_gap <= $urandom_range(1, 4);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side: compare with the oldest expectation, random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_type want;
            returned_results++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %h", $time, rsp_tdata);
               failures++;
            end else begin
               want = expected_results.pop_front();
               report_field("char_valid", want.char_valid, rsp_tuser);
               report_field("char_out", want.char_out, rsp_tdata[7:0]);
               report_field("arg_end", want.arg_end, rsp_tdata[8]);
               report_field("arg_count", want.arg_count, rsp_tdata[20:9]);
               report_field("error_code", want.error_code, rsp_tdata[22:21]);
               report_field("error_position", want.error_position, rsp_tdata[34:23]);
               report_field("string_done", want.string_done, rsp_tlast);
            end
         end
         if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
            rsp_tready <= 1'b0;
         end else if (byte_stream.size() > QUIET_TAIL && (returned_results / 160) % 3 != 1 &&
                      $urandom_range(0, 6) == 0) begin
            recv_stall <= $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int random_count;
      random_count = 0;

      // directed table
      add_row("x", 1'b1, 1'b1,
              make_result(1'b1, "x", 1'b1, 1, ERR_NONE, 0, 1'b1));
      add_row(CHR_BACKSLASH, 1'b0, 1'b1,
              make_result(1'b0, 8'd0, 1'b0, 0, ERR_NONE, 0, 1'b0));
      add_row("q", 1'b1, 1'b1,
              make_result(1'b0, 8'd0, 1'b0, 0, ERR_ESCAPE, 1, 1'b1));
      add_row(CHR_QUOTE, 1'b1, 1'b1,
              make_result(1'b0, 8'd0, 1'b0, 0, ERR_UNTERMINATED, 0, 1'b1));
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(CHR_TAB, 1'b0, 1'b0, '0);
      // empty quoted group still ends an argument
      add_row(CHR_QUOTE, 1'b0, 1'b0, '0);
      add_row(CHR_QUOTE, 1'b0, 1'b0, '0);
      // escaped space, escaped newline, quote inside text
      add_row(CHR_BACKSLASH, 1'b0, 1'b0, '0);
      add_row(CHR_SPACE, 1'b0, 1'b0, '0);
      add_row(CHR_BACKSLASH, 1'b0, 1'b0, '0);
      add_row("n", 1'b0, 1'b0, '0);
      add_row(CHR_QUOTE, 1'b0, 1'b0, '0);
      add_row(CHR_SPACE, 1'b0, 1'b0, '0);
      // escaped space inside quotes is an error, then discard to the end
      add_row(CHR_QUOTE, 1'b0, 1'b0, '0);
      add_row(CHR_BACKSLASH, 1'b0, 1'b0, '0);
      add_row(CHR_SPACE, 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row("z", 1'b1, 1'b0, '0);
      // final escaped byte closes its argument
      add_row(CHR_BACKSLASH, 1'b0, 1'b0, '0);
      add_row(CHR_QUOTE, 1'b1, 1'b0, '0);
      // string ending inside quotes
      add_row(CHR_QUOTE, 1'b0, 1'b0, '0);
      add_row(CHR_BACKSLASH, 1'b0, 1'b0, '0);
      add_row("t", 1'b0, 1'b0, '0);
      add_row("a", 1'b1, 1'b0, '0);

      // random strings
      while (random_count < RANDOM_BYTES) begin
         random_count += add_random_string();
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (byte_stream.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (10) @(posedge clock);

      if (failures == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
